@@ hw/rtl/sar_pkg.sv @@
// ----------------------------------------------------------------------------
// sar_pkg
// shared types, constants and the arctangent table of the segment rotator
// ----------------------------------------------------------------------------
`default_nettype none

package sar_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned ANGLE_WIDTH_DEF = 16;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned FULL_ANGLE_W    = 16;

  localparam int unsigned CX_W  = 20;
  localparam int unsigned CZ_W  = 18;
  localparam int unsigned CS_W  = 18;

  localparam int CORDIC_X0  = 39797;
  localparam int ONE_Q16    = 65536;
  localparam int QUARTER    = 16384;
  localparam int HALF       = 32768;
  localparam int ROUND_HALF = 32768;
  localparam int FRAC_SHIFT = 16;
  localparam int ONE_FIXED  = 256;

  localparam logic [1:0] REG_AXIS    = 2'd0;
  localparam logic [1:0] REG_ANGLE_X = 2'd1;
  localparam logic [1:0] REG_ANGLE_Y = 2'd2;
  localparam logic [1:0] REG_ANGLE_Z = 2'd3;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  typedef struct packed {
    logic                   valid;
    logic                   neg;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic  valid;
    axis_e axis;
  } rot_ctl_t;

  function automatic int atan_f(input int unsigned step);
    int r;
    case (step)
      0:       r = 8192;
      1:       r = 4836;
      2:       r = 2555;
      3:       r = 1297;
      4:       r = 651;
      5:       r = 326;
      6:       r = 163;
      7:       r = 81;
      8:       r = 41;
      9:       r = 20;
      10:      r = 10;
      11:      r = 5;
      12:      r = 3;
      13:      r = 1;
      14:      r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sar_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// sar_cordic_cell
// one registered cordic iteration with a fixed shift
// ----------------------------------------------------------------------------
`default_nettype none

module sar_cordic_cell import sar_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire cordic_t cell_i,
  output cordic_t      cell_o
);

  localparam logic signed [CZ_W-1:0] ATAN = CZ_W'(atan_f(Shift));

  cordic_t cell_d, cell_q;
  logic signed [CX_W-1:0] xs, ys;

  always_comb begin
    xs = cell_i.x >>> Shift;
    ys = cell_i.y >>> Shift;
    cell_d       = cell_i;
    if (!cell_i.z[CZ_W-1]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - ATAN;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

@@ hw/rtl/sar_rotate.sv @@
// ----------------------------------------------------------------------------
// sar_rotate
// two-stage plane rotation of both endpoints: products, then round and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module sar_rotate import sar_pkg::*; #(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire rot_ctl_t                     ctl_i,
  input  wire logic signed [CS_W-1:0]       cos_i,
  input  wire logic signed [CS_W-1:0]       sin_i,
  input  wire logic [5:0][CoordWidth-1:0]   pts_i,
  output rot_ctl_t                          ctl_o,
  output logic [5:0][CoordWidth-1:0]        pts_o
);

  localparam int unsigned PW = CoordWidth + CS_W;
  localparam int unsigned SW = PW + 2;
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

  function automatic logic [CoordWidth-1:0] round_sat(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] sh;
    sh = (acc + SW'(ROUND_HALF)) >>> FRAC_SHIFT;
    if (sh > CMAX) sh = CMAX;
    if (sh < CMIN) sh = CMIN;
    return sh[CoordWidth-1:0];
  endfunction

  rot_ctl_t ctl1_q, ctl2_q;
  logic [5:0][CoordWidth-1:0] pts1_q, pts2_q, pts2_d;
  logic signed [PW-1:0] cu_d [2], sv_d [2], su_d [2], cv_d [2];
  logic signed [PW-1:0] cu_q [2], sv_q [2], su_q [2], cv_q [2];
  logic signed [CS_W-1:0] s_eff;
  logic signed [CoordWidth-1:0] u [2], v [2];
  logic [CoordWidth-1:0] un [2], vn [2];

  always_comb begin
    s_eff = (ctl_i.axis == AXIS_X) ? -sin_i : sin_i;
    for (int p = 0; p < 2; p++) begin
      case (ctl_i.axis)
        AXIS_X: begin
          u[p] = $signed(pts_i[3*p+1]);
          v[p] = $signed(pts_i[3*p+2]);
        end
        AXIS_Z: begin
          u[p] = $signed(pts_i[3*p]);
          v[p] = $signed(pts_i[3*p+1]);
        end
        default: begin
          u[p] = $signed(pts_i[3*p]);
          v[p] = $signed(pts_i[3*p+2]);
        end
      endcase
      cu_d[p] = PW'(cos_i) * PW'(u[p]);
      sv_d[p] = PW'(s_eff) * PW'(v[p]);
      su_d[p] = PW'(s_eff) * PW'(u[p]);
      cv_d[p] = PW'(cos_i) * PW'(v[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts1_q <= pts_i;
      pts2_q <= pts2_d;
      for (int p = 0; p < 2; p++) begin
        cu_q[p] <= cu_d[p];
        sv_q[p] <= sv_d[p];
        su_q[p] <= su_d[p];
        cv_q[p] <= cv_d[p];
      end
    end
  end

  always_comb begin
    pts2_d = pts1_q;
    for (int p = 0; p < 2; p++) begin
      un[p] = round_sat(SW'(cu_q[p]) + SW'(sv_q[p]));
      vn[p] = round_sat(SW'(cv_q[p]) - SW'(su_q[p]));
      case (ctl1_q.axis)
        AXIS_X: begin
          pts2_d[3*p+1] = un[p];
          pts2_d[3*p+2] = vn[p];
        end
        AXIS_Y: begin
          pts2_d[3*p]   = un[p];
          pts2_d[3*p+2] = vn[p];
        end
        AXIS_Z: begin
          pts2_d[3*p]   = un[p];
          pts2_d[3*p+1] = vn[p];
        end
        default: ;
      endcase
    end
  end

  assign ctl_o = ctl2_q;
  assign pts_o = pts2_q;

endmodule

`default_nettype wire

@@ hw/rtl/sar_margin_cell.sv @@
// ----------------------------------------------------------------------------
// sar_margin_cell
// negative extent margin of one axis, checked for the from and to endpoints
// ----------------------------------------------------------------------------
`default_nettype none

module sar_margin_cell import sar_pkg::*; #(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  upd_i,
  input  wire logic [CoordWidth-1:0] from_i,
  input  wire logic [CoordWidth-1:0] to_i,
  output logic [CoordWidth-1:0]      margin_d_o
);

  localparam logic [CoordWidth:0] MMAX = {1'b0, {CoordWidth{1'b1}}};

  function automatic logic [CoordWidth-1:0] check(input logic [CoordWidth-1:0] m,
                                                  input logic [CoordWidth-1:0] v);
    logic [CoordWidth-1:0] mag;
    logic [CoordWidth:0]   nxt;
    logic [CoordWidth-1:0] r;
    mag = -v;
    nxt = {1'b0, mag} + (CoordWidth+1)'(ONE_FIXED);
    r   = m;
    if (v[CoordWidth-1] && (m < mag)) begin
      r = (nxt > MMAX) ? MMAX[CoordWidth-1:0] : nxt[CoordWidth-1:0];
    end
    return r;
  endfunction

  logic [CoordWidth-1:0] margin_q, margin_d;

  always_comb begin
    margin_d = margin_q;
    if (upd_i) begin
      margin_d = check(check(margin_q, from_i), to_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else begin
      margin_q <= margin_d;
    end
  end

  assign margin_d_o = margin_d;

endmodule

`default_nettype wire

@@ hw/rtl/segment_axis_rotation_top.sv @@
// ----------------------------------------------------------------------------
// segment_axis_rotation_top
// rotates both endpoints of a 3d segment about one configured axis
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              from_x..to_z
//  m_axis    out  tvalid/tready              rot_from_x..rot_to_z, margins
//  cfg       in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  one item per cycle while m_axis accepts results; 16 cordic cells, 2 rotate
//  stages and an output register
//  the whole pipeline stalls together while a result waits at m_axis
//  reset clears the config registers, the cordic cells, the margins and all valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module segment_axis_rotation_top import sar_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int unsigned IN_W  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [ANGLE_WIDTH-1:0] cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z
  input  wire logic [IN_W-1:0]        s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // rot_from_x, rot_from_y, rot_from_z, rot_to_x, rot_to_y, rot_to_z,
  // x_margin_now, y_margin_now, z_margin_now
  output logic [OUT_W-1:0]            m_axis_tdata
);

  localparam int unsigned NC = CORDIC_STEPS;
  localparam logic signed [CZ_W-1:0] ZQ = CZ_W'(QUARTER);
  localparam logic signed [CZ_W-1:0] ZH = CZ_W'(HALF);
  localparam logic signed [CX_W-1:0] XONE = CX_W'(ONE_Q16);

  axis_e                  axis_q;
  logic [ANGLE_WIDTH-1:0] ang_x_q, ang_y_q, ang_z_q, ang_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= AXIS_NONE;
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AXIS:    axis_q  <= axis_e'(cfg_data_i[1:0]);
        REG_ANGLE_X: ang_x_q <= cfg_data_i;
        REG_ANGLE_Y: ang_y_q <= cfg_data_i;
        REG_ANGLE_Z: ang_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // angle reduction into the cordic range
  logic [FULL_ANGLE_W-1:0]        a16;
  logic signed [FULL_ANGLE_W-1:0] z16;
  logic signed [CZ_W-1:0]         zx;
  cordic_t                        chain [NC+1];

  always_comb begin
    case (axis_q)
      AXIS_X:  ang_sel = ang_x_q;
      AXIS_Y:  ang_sel = ang_y_q;
      AXIS_Z:  ang_sel = ang_z_q;
      default: ang_sel = '0;
    endcase
    a16 = FULL_ANGLE_W'(ang_sel) << (FULL_ANGLE_W - ANGLE_WIDTH);
    z16 = $signed(a16);
    zx  = CZ_W'(z16);
    chain[0].valid = s_axis_tvalid;
    chain[0].neg   = 1'b0;
    chain[0].x     = CX_W'(CORDIC_X0);
    chain[0].y     = '0;
    chain[0].z     = zx;
    if (zx > ZQ) begin
      chain[0].z   = zx - ZH;
      chain[0].neg = 1'b1;
    end else if (zx < -ZQ) begin
      chain[0].z   = zx + ZH;
      chain[0].neg = 1'b1;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cells
    sar_cordic_cell #(.Shift(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // payload travels beside the cordic cells
  axis_e                       axis_pipe [NC];
  logic [5:0][COORD_WIDTH-1:0] pts_pipe  [NC];
  logic [5:0][COORD_WIDTH-1:0] pts_in;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pts_in[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      axis_pipe[0] <= axis_q;
      pts_pipe[0]  <= pts_in;
      for (int i = 1; i < NC; i++) begin
        axis_pipe[i] <= axis_pipe[i-1];
        pts_pipe[i]  <= pts_pipe[i-1];
      end
    end
  end

  // sign fix and clamp of the cordic result
  logic signed [CX_W-1:0] cx, sx;
  logic signed [CS_W-1:0] cos_v, sin_v;
  rot_ctl_t               ctl_in, ctl_out;

  always_comb begin
    cx = chain[NC].neg ? -chain[NC].x : chain[NC].x;
    sx = chain[NC].neg ? -chain[NC].y : chain[NC].y;
    if (cx > XONE)  cx = XONE;
    if (cx < -XONE) cx = -XONE;
    if (sx > XONE)  sx = XONE;
    if (sx < -XONE) sx = -XONE;
    cos_v = CS_W'(cx);
    sin_v = CS_W'(sx);
    ctl_in.valid = chain[NC].valid;
    ctl_in.axis  = axis_pipe[NC-1];
  end

  logic [5:0][COORD_WIDTH-1:0] pts_rot;

  sar_rotate #(.CoordWidth(COORD_WIDTH)) u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl_in),
    .cos_i  (cos_v),
    .sin_i  (sin_v),
    .pts_i  (pts_pipe[NC-1]),
    .ctl_o  (ctl_out),
    .pts_o  (pts_rot)
  );

  logic [2:0]                  upd;
  logic [2:0][COORD_WIDTH-1:0] marg_d;

  always_comb begin
    upd[0] = adv && ctl_out.valid && (ctl_out.axis == AXIS_Y || ctl_out.axis == AXIS_Z);
    upd[1] = adv && ctl_out.valid && (ctl_out.axis == AXIS_X || ctl_out.axis == AXIS_Z);
    upd[2] = adv && ctl_out.valid && (ctl_out.axis == AXIS_X || ctl_out.axis == AXIS_Y);
  end

  for (genvar k = 0; k < 3; k++) begin : g_margin
    sar_margin_cell #(.CoordWidth(COORD_WIDTH)) u_margin (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_i      (upd[k]),
      .from_i     (pts_rot[k]),
      .to_i       (pts_rot[k+3]),
      .margin_d_o (marg_d[k])
    );
  end

  logic [5:0][COORD_WIDTH-1:0] out_pts_q;
  logic [2:0][COORD_WIDTH-1:0] out_marg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pts_q  <= pts_rot;
      out_marg_q <= marg_d;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 6; k++) begin
      m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH] = out_pts_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      m_axis_tdata[(6+k)*COORD_WIDTH +: COORD_WIDTH] = out_marg_q[k];
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/sar_checker.sv @@
// ----------------------------------------------------------------------------
// sar_checker
// port-level checks of the segment rotator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sar_checker import sar_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned OUT_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output side");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared while pipeline stalled");

endmodule

bind segment_axis_rotation_top sar_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the segment rotator: random and directed segments
// are streamed in under varying back-pressure, and every result is compared
// with an in-bench model of the cordic, the rotation and the margin tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sar_pkg::*;

  localparam int CW    = 24;
  localparam int AW    = 16;
  localparam int IN_W  = 144;
  localparam int OUT_W = 216;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam longint UMAX = (64'sd1 <<< CW) - 1;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [AW-1:0]    cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  segment_axis_rotation_top DUT (.*);

  axis_e         cur_axis;
  logic [AW-1:0] cur_angle [3];
  longint        margin [3];

  logic [IN_W-1:0]  seg_queue [$];
  logic [OUT_W-1:0] rotated_queue [$];
  int mismatches;
  int send_idle_pct, recv_stall_pct;
  bit recv_hold;
  bit hold_req;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // long receiver hold, counted here
  always begin
    wait (hold_req);
    recv_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    recv_hold = 1'b0;
    hold_req  = 1'b0;
  end

  function automatic int atan_tab(int i);
    int t [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void sin_cos(logic [AW-1:0] ang, output longint c, output longint s);
    longint x, y, xs, ys;
    int z;
    bit neg;
    x = CORDIC_X0;
    y = 0;
    neg = 0;
    z = $signed(16'(ang));
    if (z > QUARTER) begin
      z -= HALF;
      neg = 1;
    end else if (z < -QUARTER) begin
      z += HALF;
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z -= atan_tab(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z += atan_tab(i);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = (x > 65536) ? 65536 : (x < -65536) ? -65536 : x;
    s = (y > 65536) ? 65536 : (y < -65536) ? -65536 : y;
  endfunction

  function automatic longint mix(longint ka, longint va, longint kb, longint vb);
    longint r;
    r = (ka * va + kb * vb + 32768) >>> 16;
    if (r > CMAX) r = CMAX;
    if (r < CMIN) r = CMIN;
    return r;
  endfunction

  function automatic void widen_margin(longint v, int m);
    longint w;
    if (v < 0 && margin[m] < -v) begin
      w = -v + ONE_FIXED;
      margin[m] = (w > UMAX) ? UMAX : w;
    end
  endfunction

  function automatic void rotate_endpoint(ref longint p [3], input longint c, input longint s);
    longint x, y, z;
    x = p[0];
    y = p[1];
    z = p[2];
    case (cur_axis)
      AXIS_X: begin
        p[1] = mix(c, y, -s, z);
        p[2] = mix(s, y, c, z);
        widen_margin(p[2], 2);
        widen_margin(p[1], 1);
      end
      AXIS_Y: begin
        p[0] = mix(c, x, s, z);
        p[2] = mix(-s, x, c, z);
        widen_margin(p[0], 0);
        widen_margin(p[2], 2);
      end
      AXIS_Z: begin
        p[0] = mix(c, x, s, y);
        p[1] = mix(-s, x, c, y);
        widen_margin(p[1], 1);
        widen_margin(p[0], 0);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] rotate_segment(logic [IN_W-1:0] seg);
    longint a [3], b [3];
    longint c, s;
    logic [OUT_W-1:0] r;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(seg[i*CW +: CW]);
      b[i] = $signed(seg[(i+3)*CW +: CW]);
    end
    c = 65536;
    s = 0;
    if (cur_axis != AXIS_NONE) sin_cos(cur_angle[int'(cur_axis) - 1], c, s);
    rotate_endpoint(a, c, s);
    rotate_endpoint(b, c, s);
    for (int i = 0; i < 3; i++) begin
      r[i*CW +: CW]     = a[i][CW-1:0];
      r[(i+3)*CW +: CW] = b[i][CW-1:0];
      r[(i+6)*CW +: CW] = margin[i][CW-1:0];
    end
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (seg_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= seg_queue[0];
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rotated_queue.push_back(rotate_segment(s_axis_tdata));
        void'(seg_queue.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (rotated_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h", m_axis_tdata);
        end else begin
          exp_r = rotated_queue.pop_front();
          for (int f = 0; f < 9; f++)
            if (m_axis_tdata[f*CW +: CW] !== exp_r[f*CW +: CW]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("field %0d: expected %h, got %h", f, exp_r[f*CW +: CW],
                         m_axis_tdata[f*CW +: CW]);
            end
        end
      end
    end
  end

  task automatic wait_idle();
    while (seg_queue.size() > 0 || rotated_queue.size() > 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [AW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_AXIS:    cur_axis = axis_e'(val[1:0]);
      REG_ANGLE_X: cur_angle[0] = val;
      REG_ANGLE_Y: cur_angle[1] = val;
      default:     cur_angle[2] = val;
    endcase
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return CW'($urandom_range(4095)) - 24'd2048;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_segment();
    logic [IN_W-1:0] s;
    for (int i = 0; i < 6; i++) s[i*CW +: CW] = rand_coord();
    return s;
  endfunction

  initial begin
    logic [AW-1:0] angs [8] = '{16'h0000, 16'hffff, 16'h4000, 16'h8000,
                                16'hc000, 16'h2000, 16'h4001, 16'hbfff};
    logic [CW-1:0] ext [4] = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff};
    mismatches = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_AXIS;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_axis = AXIS_NONE;
    cur_angle = '{default: '0};
    margin = '{default: 0};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes under each axis
    for (int a = 0; a < 4; a++) begin
      write_reg(REG_AXIS, AW'(a));
      write_reg(REG_ANGLE_X, angs[a]);
      write_reg(REG_ANGLE_Y, angs[a + 2]);
      write_reg(REG_ANGLE_Z, angs[a + 4]);
      for (int k = 0; k < 5; k++) begin
        logic [IN_W-1:0] s;
        for (int i = 0; i < 6; i++) s[i*CW +: CW] = ext[(i + k) % 4];
        seg_queue.push_back(s);
      end
      wait_idle();
    end

    // random phases across idling modes and settings
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      write_reg(REG_AXIS, AW'(ph < 4 ? ph : $urandom_range(3)));
      write_reg(REG_ANGLE_X, ph < 8 ? angs[ph] : AW'($urandom));
      write_reg(REG_ANGLE_Y, ph < 8 ? angs[7 - ph] : AW'($urandom));
      write_reg(REG_ANGLE_Z, ph < 8 ? angs[(ph + 3) % 8] : AW'($urandom));
      if (ph == 5) hold_req = 1'b1;
      for (int n = 0; n < 55; n++) seg_queue.push_back(rand_segment());
      wait_idle();
    end

    if (mismatches == 0)
      $display("** segment_axis_rotation_top: PASSED **");
    else
      $display("** segment_axis_rotation_top: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** segment_axis_rotation_top: FAILED **");
    $finish;
  end

endmodule
